// ===== design/ralc_pkg.sv =====
// Shared types and constants for the reverse looper with crossfade.
package ralc_pkg;

    localparam int LEN_W      = 20;
    localparam int FADE_W     = 19;
    localparam int GAIN_W     = 16;
    localparam int WGT_W      = GAIN_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int PHASE_W    = 2;

    localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << GAIN_W;

    localparam logic [CFG_IDX_W-1:0] CFG_RUN_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_LENGTH   = 2'd2;

    typedef enum logic [PHASE_W-1:0] {
        PH_STOP   = 2'd0,
        PH_RECORD = 2'd1,
        PH_PLAY   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        MIX_THRU,
        MIX_OPEN,
        MIX_CLOSE,
        MIX_REV
    } mix_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_FETCH,
        ST_GAIN,
        ST_SUM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic mul_en;
        logic sum_en;
    } lane_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== design/ralc_ram.sv =====
// Generic single-port RAM with registered read.
module ralc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ralc_div.sv =====
// Radix-2 restoring divider for the crossfade gain, (num << 16) / den.
module ralc_div
    import ralc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [FADE_W-1:0] num,
    input  logic [FADE_W-1:0] den,
    output div_stat_t         stat,
    output logic [GAIN_W-1:0] quot
);

    localparam int CNT_W = $clog2(GAIN_W + 1);

    logic [FADE_W-1:0] rem_reg, rem_next;
    logic [FADE_W-1:0] den_reg;
    logic [GAIN_W-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [FADE_W:0]   rem_sh;

    always_comb begin
        rem_sh    = {rem_reg, 1'b0};
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (rem_sh >= {1'b0, den_reg}) begin
            rem_next  = FADE_W'(rem_sh - {1'b0, den_reg});
            quot_next = {quot_reg[GAIN_W-2:0], 1'b1};
        end else begin
            rem_next  = FADE_W'(rem_sh);
            quot_next = {quot_reg[GAIN_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(GAIN_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= num;
            den_reg  <= den;
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule

// ===== design/ralc_lane.sv =====
// One channel lane: weighted mix of dry and reversed sample, rounded half up.
module ralc_lane
    import ralc_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  lane_ctrl_t                    ctrl,
    input  logic signed [SAMPLE_BITS-1:0] dry,
    input  logic signed [SAMPLE_BITS-1:0] rev,
    input  logic [WGT_W-1:0]              w_dry,
    input  logic [WGT_W-1:0]              w_rev,
    output logic signed [SAMPLE_BITS-1:0] result
);

    localparam int PROD_W = SAMPLE_BITS + WGT_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (GAIN_W - 1);

    logic signed [WGT_W:0]            w_dry_s, w_rev_s;
    logic signed [PROD_W-1:0]         prod_dry_reg, prod_dry_next;
    logic signed [PROD_W-1:0]         prod_rev_reg, prod_rev_next;
    logic signed [SUM_W-1:0]          sum_next;
    logic signed [SAMPLE_BITS-1:0]    result_reg;

    always_comb begin
        w_dry_s       = $signed({1'b0, w_dry});
        w_rev_s       = $signed({1'b0, w_rev});
        prod_dry_next = PROD_W'(dry) * PROD_W'(w_dry_s);
        prod_rev_next = PROD_W'(rev) * PROD_W'(w_rev_s);
        sum_next      = SUM_W'(prod_dry_reg) + SUM_W'(prod_rev_reg) + ROUND_HALF;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_dry_reg <= prod_dry_next;
            prod_rev_reg <= prod_rev_next;
        end
        if (ctrl.sum_en) begin
            result_reg <= sum_next[GAIN_W +: SAMPLE_BITS];
        end
    end

    assign result = result_reg;

endmodule

// ===== design/reverse_audio_looper_crossfade_unit.sv =====
// Top level of the reverse audio looper with linear crossfade.
//
// One stereo frame per request; phases alternate record / reversed playback
// every buffer_length frames while run_enable is set. Frames are handled one
// at a time, through the prep, fetch, gain, sum and out states to the output
// register; inside the fade zones the gain state waits for the 16-step gain
// divider. The next frame is accepted once the state machine is back in idle.
// The sample store is a single-port RAM, written or read once per frame.
// After a configuration write the input stays blocked while the settle
// counter runs down and the clamped lengths settle. The result register lets
// the next frame be accepted while a result waits.
module reverse_audio_looper_crossfade_unit
    import ralc_pkg::*;
#(
    parameter int MAX_FRAMES  = 524288,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [CFG_IDX_W-1:0]               cfg_index,
    input  logic [CFG_DATA_W-1:0]              cfg_data,
    // input frames
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,  // left_in, right_in
    // result frames
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,  // left_out, right_out
    output logic [PHASE_W-1:0]                 m_axis_tuser   // phase_out
);

    localparam int DATA_W = 2 * SAMPLE_BITS;
    localparam int AXIS_W = ((DATA_W + 7) / 8) * 8;
    localparam int ADDR_W = $clog2(MAX_FRAMES);

    // configuration and derived lengths
    logic              cfg_fire;
    logic              cfg_run_reg;
    logic [LEN_W-1:0]  cfg_len_reg;
    logic [FADE_W-1:0] cfg_fade_reg;
    logic [1:0]        settle_reg;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [FADE_W-1:0] fade_reg, fade_next;
    logic [LEN_W-1:0]  len_m1_reg;
    logic [LEN_W-1:0]  lenf_reg;

    // control
    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic              s_fire;

    // item
    logic signed [SAMPLE_BITS-1:0] in_l_reg, in_r_reg;
    logic signed [SAMPLE_BITS-1:0] rev_l_reg, rev_r_reg;
    mix_mode_t         mode_reg, mode_next;
    phase_t            item_phase_reg;
    logic              need_div_reg;

    // prep stage
    logic              active;
    phase_t            phase0;
    logic [LEN_W-1:0]  pos_a, pos0, rd_idx, close_num;
    logic              fade_open, fade_close;
    logic [FADE_W-1:0] div_num;

    // memory
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [DATA_W-1:0] ram_rdata;

    // divider and lanes
    logic              div_start;
    div_stat_t         div_stat;
    logic [GAIN_W-1:0] gain;
    lane_ctrl_t        lane_ctrl;
    logic [WGT_W-1:0]  w_dry, w_rev;
    logic signed [SAMPLE_BITS-1:0] res_l, res_r;

    // output register
    logic              m_valid_reg;
    logic [DATA_W-1:0] m_data_reg;
    phase_t            m_phase_reg;
    logic              out_load;

    assign cfg_ready     = 1'b1;
    assign cfg_fire      = cfg_valid & cfg_ready;
    assign s_axis_tready = (state_reg == ST_IDLE) && (settle_reg == 2'd0) && !cfg_valid;
    assign s_fire        = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_run_reg  <= 1'b0;
            cfg_len_reg  <= LEN_W'(441000);
            cfg_fade_reg <= FADE_W'(88200);
            settle_reg   <= 2'd3;
        end else begin
            if (cfg_fire) begin
                case (cfg_index)
                    CFG_RUN_ENABLE:    cfg_run_reg  <= cfg_data[0];
                    CFG_BUFFER_LENGTH: cfg_len_reg  <= cfg_data[LEN_W-1:0];
                    CFG_FADE_LENGTH:   cfg_fade_reg <= cfg_data[FADE_W-1:0];
                    default:           ;
                endcase
                settle_reg <= 2'd3;
            end else if (settle_reg != 2'd0) begin
                settle_reg <= settle_reg - 2'd1;
            end
        end
    end

    always_comb begin
        if (cfg_len_reg < LEN_W'(2)) begin
            len_next = LEN_W'(2);
        end else if (32'(cfg_len_reg) > 32'(MAX_FRAMES)) begin
            len_next = LEN_W'(MAX_FRAMES);
        end else begin
            len_next = cfg_len_reg;
        end
        if (cfg_fade_reg > len_reg[LEN_W-1:1]) begin
            fade_next = len_reg[LEN_W-1:1];
        end else begin
            fade_next = cfg_fade_reg;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg    <= len_next;
        fade_reg   <= fade_next;
        len_m1_reg <= len_reg - LEN_W'(1);
        lenf_reg   <= len_reg - LEN_W'(fade_reg);
    end

    // frame position, phase and fade zone
    always_comb begin
        active = cfg_run_reg && (phase_reg == PH_RECORD || phase_reg == PH_PLAY);
        if (!cfg_run_reg) begin
            phase0 = PH_STOP;
        end else if (active) begin
            phase0 = phase_reg;
        end else begin
            phase0 = PH_RECORD;
        end
        pos_a      = active ? pos_reg : '0;
        pos0       = (pos_a >= len_reg) ? '0 : pos_a;
        rd_idx     = len_m1_reg - pos0;
        close_num  = pos0 - lenf_reg;
        fade_open  = (fade_reg != '0) && (pos0 < LEN_W'(fade_reg));
        fade_close = !fade_open && (pos0 > lenf_reg);
        div_num    = fade_open ? pos0[FADE_W-1:0] : close_num[FADE_W-1:0];

        case (phase0)
            PH_PLAY: begin
                if (fade_open) begin
                    mode_next = MIX_OPEN;
                end else if (fade_close) begin
                    mode_next = MIX_CLOSE;
                end else begin
                    mode_next = MIX_REV;
                end
            end
            default: mode_next = MIX_THRU;
        endcase

        if (phase0 == PH_STOP) begin
            pos_next   = '0;
            phase_next = PH_STOP;
        end else if (pos0 == len_m1_reg) begin
            pos_next   = '0;
            phase_next = (phase0 == PH_RECORD) ? PH_PLAY : PH_RECORD;
        end else begin
            pos_next   = pos0 + LEN_W'(1);
            phase_next = phase0;
        end
    end

    assign ram_we    = (state_reg == ST_PREP) && (phase0 == PH_RECORD);
    assign ram_addr  = (phase0 == PH_RECORD) ? ADDR_W'(pos0) : ADDR_W'(rd_idx);
    assign div_start = (state_reg == ST_PREP) && (phase0 == PH_PLAY)
                       && (fade_open || fade_close);

    ralc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_FRAMES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata ({in_r_reg, in_l_reg}),
        .rdata (ram_rdata)
    );

    ralc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (fade_reg),
        .stat    (div_stat),
        .quot    (gain)
    );

    always_comb begin
        case (mode_reg)
            MIX_OPEN: begin
                w_dry = WGT_ONE - WGT_W'(gain);
                w_rev = WGT_W'(gain);
            end
            MIX_CLOSE: begin
                w_dry = WGT_W'(gain);
                w_rev = WGT_ONE - WGT_W'(gain);
            end
            MIX_REV: begin
                w_dry = '0;
                w_rev = WGT_ONE;
            end
            default: begin
                w_dry = WGT_ONE;
                w_rev = '0;
            end
        endcase
    end

    ralc_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_l (
        .aclk   (aclk),
        .ctrl   (lane_ctrl),
        .dry    (in_l_reg),
        .rev    (rev_l_reg),
        .w_dry  (w_dry),
        .w_rev  (w_rev),
        .result (res_l)
    );

    ralc_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_r (
        .aclk   (aclk),
        .ctrl   (lane_ctrl),
        .dry    (in_r_reg),
        .rev    (rev_r_reg),
        .w_dry  (w_dry),
        .w_rev  (w_rev),
        .result (res_r)
    );

    always_comb begin
        state_next       = state_reg;
        lane_ctrl.mul_en = 1'b0;
        lane_ctrl.sum_en = 1'b0;
        out_load         = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:  state_next = ST_FETCH;
            ST_FETCH: state_next = ST_GAIN;
            ST_GAIN: begin
                if (!need_div_reg || div_stat.done) begin
                    lane_ctrl.mul_en = 1'b1;
                    state_next       = ST_SUM;
                end
            end
            ST_SUM: begin
                lane_ctrl.sum_en = 1'b1;
                state_next       = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_STOP;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_PREP) begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_l_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
            in_r_reg <= s_axis_tdata[DATA_W-1:SAMPLE_BITS];
        end
        if (state_reg == ST_PREP) begin
            mode_reg       <= mode_next;
            item_phase_reg <= phase0;
            need_div_reg   <= div_start;
        end
        if (state_reg == ST_FETCH) begin
            if (item_phase_reg == PH_PLAY) begin
                rev_l_reg <= ram_rdata[SAMPLE_BITS-1:0];
                rev_r_reg <= ram_rdata[DATA_W-1:SAMPLE_BITS];
            end else begin
                rev_l_reg <= '0;
                rev_r_reg <= '0;
            end
        end
        if (out_load) begin
            m_data_reg  <= {res_r, res_l};
            m_phase_reg <= item_phase_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = AXIS_W'(m_data_reg);
    assign m_axis_tuser  = m_phase_reg;

endmodule

// ===== verif/reverse_audio_looper_crossfade_checker.sv =====
`timescale 1ns / 100ps
// Checker for the reverse looper: tracks registers and frames, predicts and compares results.
module reverse_audio_looper_crossfade_checker
    import ralc_pkg::*;
#(
    parameter int MAX_FRAMES  = 524288,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [CFG_IDX_W-1:0]               cfg_index,
    input  logic [CFG_DATA_W-1:0]              cfg_data,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,  // left_in, right_in
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,  // left_out, right_out
    input  logic [PHASE_W-1:0]                 m_axis_tuser,  // phase_out
    output int                                 mismatches,
    output int                                 pending
);

    localparam int LEN_AT_RESET  = 441000;
    localparam int FADE_AT_RESET = 88200;

    typedef struct packed {
        phase_t                 phase;
        logic [SAMPLE_BITS-1:0] right;
        logic [SAMPLE_BITS-1:0] left;
    } frame_result_t;

    logic              run_en;
    logic [LEN_W-1:0]  len_reg;
    logic [FADE_W-1:0] fade_reg;
    int unsigned       loop_pos;
    phase_t            loop_phase;

    logic [2*SAMPLE_BITS-1:0] frame_store [int unsigned];
    frame_result_t            expected_q [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
        mismatches++;
    endtask

    // Q0.16 crossfade, a weighted by (1 - g), rounded half up
    function automatic logic [SAMPLE_BITS-1:0] blend(input longint a, input longint b,
                                                     input longint g);
        longint acc;
        acc = a * ((longint'(1) << GAIN_W) - g) + b * g;
        acc = (acc + (longint'(1) << (GAIN_W - 1))) >>> GAIN_W;
        return acc[SAMPLE_BITS-1:0];
    endfunction

    task automatic advance_loop(input logic signed [SAMPLE_BITS-1:0] l,
                                input logic signed [SAMPLE_BITS-1:0] r,
                                output frame_result_t res);
        int unsigned len;
        int unsigned fade;
        longint gain;
        logic [2*SAMPLE_BITS-1:0] rev;
        logic signed [SAMPLE_BITS-1:0] rev_l;
        logic signed [SAMPLE_BITS-1:0] rev_r;

        len = 32'(len_reg);
        if (len < 2)
            len = 2;
        if (len > MAX_FRAMES)
            len = MAX_FRAMES;
        fade = 32'(fade_reg);
        if (fade > len / 2)
            fade = len / 2;

        if (!run_en) begin
            loop_phase = PH_STOP;
            loop_pos   = 0;
        end else if (loop_phase != PH_RECORD && loop_phase != PH_PLAY) begin
            loop_phase = PH_RECORD;
            loop_pos   = 0;
        end
        if (loop_pos >= len)
            loop_pos = 0;

        res.left  = l;
        res.right = r;
        res.phase = loop_phase;
        case (loop_phase)
            PH_RECORD: begin
                frame_store[loop_pos] = {r, l};
            end
            PH_PLAY: begin
                rev   = frame_store[len - 1 - loop_pos];
                rev_l = rev[SAMPLE_BITS-1:0];
                rev_r = rev[2*SAMPLE_BITS-1:SAMPLE_BITS];
                if (fade != 0 && loop_pos < fade) begin
                    gain      = (longint'(loop_pos) << GAIN_W) / fade;
                    res.left  = blend(l, rev_l, gain);
                    res.right = blend(r, rev_r, gain);
                end else if (loop_pos > len - fade) begin
                    gain      = (longint'(loop_pos - (len - fade)) << GAIN_W) / fade;
                    res.left  = blend(rev_l, l, gain);
                    res.right = blend(rev_r, r, gain);
                end else begin
                    res.left  = rev_l;
                    res.right = rev_r;
                end
            end
            default: ;
        endcase

        if (loop_phase != PH_STOP) begin
            loop_pos++;
            if (loop_pos >= len) begin
                loop_pos   = 0;
                loop_phase = (loop_phase == PH_RECORD) ? PH_PLAY : PH_RECORD;
            end
        end
    endtask

    // results are taken before requests: a result never belongs to a request of the same edge
    always @(posedge aclk) begin
        frame_result_t want;
        frame_result_t fresh;

        if (!aresetn) begin
            run_en     = 1'b0;
            len_reg    = LEN_W'(LEN_AT_RESET);
            fade_reg   = FADE_W'(FADE_AT_RESET);
            loop_pos   = 0;
            loop_phase = PH_STOP;
            mismatches = 0;
            expected_q.delete();
            pending <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result with none expected", 32'(m_axis_tdata), '0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_axis_tdata[SAMPLE_BITS-1:0] !== want.left)
                        report_mismatch("left_out", 32'(m_axis_tdata[SAMPLE_BITS-1:0]),
                                        32'(want.left));
                    if (m_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS] !== want.right)
                        report_mismatch("right_out",
                                        32'(m_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
                                        32'(want.right));
                    if (m_axis_tuser !== want.phase)
                        report_mismatch("phase_out", 32'(m_axis_tuser), 32'(want.phase));
                end
            end

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_RUN_ENABLE:    run_en   = cfg_data[0];
                    CFG_BUFFER_LENGTH: len_reg  = cfg_data[LEN_W-1:0];
                    CFG_FADE_LENGTH:   fade_reg = cfg_data[FADE_W-1:0];
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready) begin
                advance_loop(s_axis_tdata[SAMPLE_BITS-1:0],
                             s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS], fresh);
                expected_q.push_back(fresh);
            end

            pending <= expected_q.size();
        end
    end

endmodule

// ===== verif/reverse_audio_looper_crossfade_unit_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the reverse looper: clock, reset, frame and register stimulus, verdict.
module reverse_audio_looper_crossfade_unit_tb
    import ralc_pkg::*;
();

    localparam int MAX_FRAMES   = 524288;
    localparam int SAMPLE_BITS  = 16;
    localparam int DATA_W       = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int TOTAL_FRAMES = 730;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int FADE_MAX     = 262144;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DATA_W-1:0]     m_axis_tdata;
    logic [PHASE_W-1:0]    m_axis_tuser;

    int          mismatches;
    int          pending;
    int          frames_sent = 0;
    int unsigned cycles      = 0;
    bit          hold_req    = 1'b0;
    bit          no_gaps     = 1'b0;

    reverse_audio_looper_crossfade_unit #(
        .MAX_FRAMES (MAX_FRAMES),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) DUT (.*);

    reverse_audio_looper_crossfade_checker #(
        .MAX_FRAMES (MAX_FRAMES),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) checker_i (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return SAMPLE_MIN;
        if (roll < 16)
            return SAMPLE_MAX;
        if (roll < 20)
            return '0;
        if (roll < 24)
            return '1;
        return SAMPLE_BITS'($urandom());
    endfunction

    function automatic int pick_fade(input int len);
        case ($urandom_range(0, 9))
            0: return 0;
            1: return len / 2;
            2: return FADE_MAX;
            3: return $urandom_range(len / 2, FADE_MAX - 1);
            4: return 1;
            default: return $urandom_range(0, len / 2);
        endcase
    endfunction

    // leaves tvalid high; the next request or settle() changes it in the same step
    task automatic push_frame(input logic [SAMPLE_BITS-1:0] left,
                              input logic [SAMPLE_BITS-1:0] right);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        cfg_valid <= 1'b0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {right, left};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        frames_sent++;
    endtask

    task automatic push_random(input int n);
        repeat (n) push_frame(pick_sample(), pick_sample());
    endtask

    // sender pauses until every result is back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        cfg_valid     <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // one stopped frame first, so a longer length never plays unrecorded frames
    task automatic restart_loop(input int len, input int fade);
        settle();
        write_reg(CFG_RUN_ENABLE, CFG_DATA_W'(0));
        push_random(1);
        settle();
        write_reg(CFG_BUFFER_LENGTH, CFG_DATA_W'(len));
        write_reg(CFG_FADE_LENGTH, CFG_DATA_W'(fade));
        write_reg(CFG_RUN_ENABLE, CFG_DATA_W'(1));
    endtask

    initial begin
        int gap;
        wait (aresetn);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                gap = no_gaps ? 0 : pick_gap();
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                m_axis_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        int roll;
        int len;
        int count;
        int segment;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // stopped passthrough at the sample extremes
        push_frame(SAMPLE_MIN, SAMPLE_MAX);
        push_frame(SAMPLE_MAX, SAMPLE_MIN);
        push_frame('0, '1);

        // start, record four, reverse four with fade of half the buffer
        settle();
        write_reg(CFG_BUFFER_LENGTH, CFG_DATA_W'(4));
        write_reg(CFG_FADE_LENGTH, CFG_DATA_W'(2));
        write_reg(CFG_RUN_ENABLE, CFG_DATA_W'(1));
        push_random(8);

        // oversized fade gets clamped
        settle();
        write_reg(CFG_FADE_LENGTH, CFG_DATA_W'(FADE_MAX));
        push_random(6);

        // length below minimum, mid playback: position restarts, phase kept
        settle();
        write_reg(CFG_BUFFER_LENGTH, CFG_DATA_W'(1));
        push_random(2);

        // full-size buffer, no fade, then shrink mid record
        settle();
        write_reg(CFG_BUFFER_LENGTH, CFG_DATA_W'(MAX_FRAMES));
        write_reg(CFG_FADE_LENGTH, CFG_DATA_W'(0));
        push_random(3);
        settle();
        write_reg(CFG_BUFFER_LENGTH, CFG_DATA_W'(2));
        push_random(4);

        segment = 0;
        while (frames_sent < TOTAL_FRAMES) begin
            roll    = $urandom_range(0, 99);
            no_gaps = ($urandom_range(0, 3) == 0);
            if (roll < 8 && segment != 0) begin
                settle();
                write_reg(CFG_RUN_ENABLE, CFG_DATA_W'(0));
                case ($urandom_range(0, 4))
                    0: write_reg(CFG_BUFFER_LENGTH, CFG_DATA_W'(0));
                    1: write_reg(CFG_BUFFER_LENGTH, '1);
                    2: write_reg(CFG_BUFFER_LENGTH, CFG_DATA_W'(MAX_FRAMES));
                    default: write_reg(CFG_BUFFER_LENGTH, CFG_DATA_W'($urandom()));
                endcase
                push_random($urandom_range(2, 8));
            end else begin
                len = (roll < 90) ? $urandom_range(2, 24) : $urandom_range(25, 64);
                restart_loop(len, pick_fade(len));
                count = $urandom_range(len, 4 * len + 3);
                if (segment == 0 || roll < 20) begin
                    // long receiver stall while frames keep coming
                    hold_req = 1'b1;
                    if (count < 40)
                        count = 40;
                end
                push_random(count);
                if (roll % 3 == 0) begin
                    settle();
                    if (roll % 2 == 0)
                        write_reg(CFG_BUFFER_LENGTH, CFG_DATA_W'($urandom_range(0, len)));
                    write_reg(CFG_FADE_LENGTH, CFG_DATA_W'(pick_fade(len)));
                    push_random($urandom_range(len, 3 * len));
                end
            end
            segment++;
        end

        no_gaps = 1'b0;
        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
